// ===== src/hbs_pkg.sv =====
`default_nettype none

package hbs_pkg;

	localparam int SAMPLE_W   = 8;
	localparam int CFG_DIM_W  = 11;
	localparam int GAIN_W     = 16;
	localparam int COORD_W    = 10;
	localparam int HEIGHT_W   = 24;
	localparam int COLSUM_W   = 10;
	localparam int SUM_W      = 12;
	localparam int PROD_W     = 28;
	localparam int RECIP_W    = 32;
	localparam int RECIP_SHIFT = 33;
	localparam int NUM_SLOTS  = 4;
	localparam int Q_DEPTH    = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_PAD_W  = OUT_TDATA_W - 2 * COORD_W - HEIGHT_W;

	localparam logic [CFG_DIM_W-1:0] RESET_GRID_DIM = 11'd1024;
	localparam logic [GAIN_W-1:0]    RESET_GAIN     = 16'd256;

	// ceil(2^33 / 9) and ceil(2^33 / 3), both exact for products below 2^33
	localparam logic [RECIP_W-1:0] RECIP_9 = 32'd954437177;
	localparam logic [RECIP_W-1:0] RECIP_3 = 32'd2863311531;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_WIDTH  = 2'd0,
		REG_GRID_HEIGHT = 2'd1,
		REG_HEIGHT_GAIN = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CNT4,
		CNT6,
		CNT9
	} count_t;

	// result slots of one sample: above-left, above, left, this point
	typedef enum logic [1:0] {
		SLOT_A,
		SLOT_B,
		SLOT_C,
		SLOT_D
	} slot_t;

	typedef enum logic {
		F_IDLE,
		F_WORK
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_PICK,
		B_MUL,
		B_DIV,
		B_OUT
	} back_state_t;

	typedef struct packed {
		logic [NUM_SLOTS-1:0]             has;
		logic [NUM_SLOTS-1:0][SUM_W-1:0]  sum;
		logic [NUM_SLOTS-1:0][1:0]        cnt;
		logic [COORD_W-1:0]               col_prev;
		logic [COORD_W-1:0]               col_cur;
		logic [COORD_W-1:0]               row_prev;
		logic [COORD_W-1:0]               row_cur;
	} entry_t;

endpackage

`default_nettype wire

// ===== src/heightmap_box_smooth_3x3.sv =====
`default_nettype none

// channel   direction  beat contents
// s_axis    in         tdata[7:0] height_sample
// m_axis    out        tdata col/row/height, tlast last_of_run, tuser frame_end
// cfg       in         cfg_index selects grid_width, grid_height or height_gain
//
// the front handles a sample as a line buffer read, then a window and buffer update, before it takes the next
// the back pops a sample's entry, then takes each result through select, gain multiply,
// reciprocal multiply and output hold, the hold lasting while m_axis_tready stays low, and pops
// no further entry until the last result is taken; a sample gives 0 to 4 results
// a 2-entry queue between front and back lets either side stall alone
// reset is asynchronous; line buffers are not cleared and are read only once written
// a width or height write restarts the frame at column 0, row 0

module heightmap_box_smooth_3x3 #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [hbs_pkg::SAMPLE_W-1:0]       s_axis_tdata,  // [7:0] height_sample
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// [9:0] out_col, [19:10] out_row, [43:20] smoothed_height, [47:44] zero
	output logic [hbs_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
	output logic                                    m_axis_tlast,
	output logic                                    m_axis_tuser,  // [0] frame_end
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [hbs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [hbs_pkg::GAIN_W-1:0]         cfg_data
);

	logic [hbs_pkg::CFG_DIM_W-1:0] grid_width_q, grid_height_q;
	logic [hbs_pkg::GAIN_W-1:0]    height_gain_q;
	logic                          cfg_we, restart;

	logic            push, q_space, q_avail, pop;
	hbs_pkg::entry_t push_entry, head;

	logic [hbs_pkg::COORD_W-1:0]  out_col, out_row;
	logic [hbs_pkg::HEIGHT_W-1:0] out_height;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign restart   = cfg_we && (cfg_index == hbs_pkg::REG_GRID_WIDTH ||
		cfg_index == hbs_pkg::REG_GRID_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= hbs_pkg::RESET_GRID_DIM;
			grid_height_q <= hbs_pkg::RESET_GRID_DIM;
			height_gain_q <= hbs_pkg::RESET_GAIN;
		end else if (cfg_we) begin
			case (cfg_index)
				hbs_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_data[hbs_pkg::CFG_DIM_W-1:0];
				hbs_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_data[hbs_pkg::CFG_DIM_W-1:0];
				hbs_pkg::REG_HEIGHT_GAIN: height_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	hbs_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_sample  (s_axis_tdata),
		.grid_width (grid_width_q),
		.grid_height(grid_height_q),
		.restart    (restart),
		.q_space    (q_space),
		.push       (push),
		.push_entry (push_entry)
	);

	hbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_entry),
		.space    (q_space),
		.pop      (pop),
		.pop_data (head),
		.avail    (q_avail)
	);

	hbs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_avail      (q_avail),
		.pop          (pop),
		.head         (head),
		.height_gain  (height_gain_q),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_col      (out_col),
		.out_row      (out_row),
		.out_height   (out_height),
		.out_last     (m_axis_tlast),
		.out_frame_end(m_axis_tuser)
	);

	assign m_axis_tdata = {{hbs_pkg::OUT_PAD_W{1'b0}}, out_height, out_row, out_col};

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> q_space)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_avail)
		else $error("queue read while empty");

	a_frame_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("frame end beat not marked last");

	a_frame_end_corner: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
		(out_col == hbs_pkg::COORD_W'(grid_width_q - 1'b1) || grid_width_q < 11'd2 ||
		 grid_width_q > 11'(MAX_WIDTH)))
		else $error("frame end beat not on last column");

endmodule

`default_nettype wire

// ===== src/hbs_ram.sv =====
`default_nettype none

module hbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== src/hbs_front.sv =====
`default_nettype none

module hbs_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [hbs_pkg::SAMPLE_W-1:0]   in_sample,
	input  wire logic [hbs_pkg::CFG_DIM_W-1:0]  grid_width,
	input  wire logic [hbs_pkg::CFG_DIM_W-1:0]  grid_height,
	input  wire logic                           restart,
	input  wire logic                           q_space,
	output logic                                push,
	output hbs_pkg::entry_t                     push_entry
);

	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int HW   = $clog2(MAX_HEIGHT);
	localparam int CTW  = AW + 1;
	localparam int RTW  = HW + 1;
	localparam int WCW  = (CTW > hbs_pkg::CFG_DIM_W) ? CTW : hbs_pkg::CFG_DIM_W;
	localparam int HCW  = (RTW > hbs_pkg::CFG_DIM_W) ? RTW : hbs_pkg::CFG_DIM_W;
	localparam int SW   = hbs_pkg::SAMPLE_W;
	localparam int CSW  = hbs_pkg::COLSUM_W;
	localparam int SMW  = hbs_pkg::SUM_W;
	localparam int CDW  = hbs_pkg::COORD_W;

	hbs_pkg::front_state_t state_q, state_d;

	logic [AW-1:0]         col_q;
	logic [HW-1:0]         row_q;
	logic [SW-1:0]         smp_q;
	logic [5:0][SW-1:0]    win_q;
	logic [2*SW-1:0]       rd;

	logic [WCW-1:0] gw_ext;
	logic [HCW-1:0] gh_ext;
	logic [CTW-1:0] w_lim;
	logic [RTW-1:0] h_lim;
	logic           last_col, last_row, use_top, use_c0, row_nz, col_nz;
	logic [SW-1:0]  older, newer, top, mid;
	logic [CSW-1:0] colr0, colr1, colr2, colp0, colp1, colp2;
	logic [AW-1:0]  col_m1;
	logic [HW-1:0]  row_m1;
	logic           accept, working;

	// size clamp to [2, max]
	always_comb begin
		gw_ext = WCW'(grid_width);
		gh_ext = HCW'(grid_height);
		if (gw_ext < WCW'(2)) begin
			w_lim = CTW'(2);
		end else if (gw_ext > WCW'(MAX_WIDTH)) begin
			w_lim = CTW'(MAX_WIDTH);
		end else begin
			w_lim = CTW'(gw_ext);
		end
		if (gh_ext < HCW'(2)) begin
			h_lim = RTW'(2);
		end else if (gh_ext > HCW'(MAX_HEIGHT)) begin
			h_lim = RTW'(MAX_HEIGHT);
		end else begin
			h_lim = RTW'(gh_ext);
		end
	end

	assign in_ready = (state_q == hbs_pkg::F_IDLE) && q_space;
	assign accept   = in_valid && in_ready;
	assign working  = (state_q == hbs_pkg::F_WORK);

	// line buffers share one word: newer row high, older row low
	hbs_ram #(
		.WIDTH(2 * SW),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk  (clk),
		.we   (working),
		.waddr(col_q),
		.wdata({smp_q, newer}),
		.raddr(col_q),
		.rdata(rd)
	);

	always_comb begin
		newer    = rd[2*SW-1:SW];
		older    = rd[SW-1:0];
		row_nz   = (row_q != '0);
		col_nz   = (col_q != '0);
		use_top  = ({1'b0, row_q} >= RTW'(2));
		use_c0   = ({1'b0, col_q} >= CTW'(2));
		top      = use_top ? older : '0;
		mid      = row_nz ? newer : '0;
		last_col = ({1'b0, col_q} == (w_lim - CTW'(1)));
		last_row = ({1'b0, row_q} == (h_lim - RTW'(1)));
		col_m1   = col_q - AW'(1);
		row_m1   = row_q - HW'(1);

		colp0 = CSW'(win_q[1]) + CSW'(win_q[2]);
		colp1 = CSW'(win_q[4]) + CSW'(win_q[5]);
		colp2 = CSW'(mid) + CSW'(smp_q);
		colr0 = colp0 + (use_top ? CSW'(win_q[0]) : CSW'(0));
		colr1 = colp1 + (use_top ? CSW'(win_q[3]) : CSW'(0));
		colr2 = colp2 + CSW'(top);

		push_entry.has[hbs_pkg::SLOT_A] = row_nz && col_nz;
		push_entry.has[hbs_pkg::SLOT_B] = row_nz && last_col;
		push_entry.has[hbs_pkg::SLOT_C] = row_nz && last_row && col_nz;
		push_entry.has[hbs_pkg::SLOT_D] = row_nz && last_row && last_col;

		push_entry.sum[hbs_pkg::SLOT_A] = (use_c0 ? SMW'(colr0) : SMW'(0))
			+ SMW'(colr1) + SMW'(colr2);
		push_entry.sum[hbs_pkg::SLOT_B] = SMW'(colr1) + SMW'(colr2);
		push_entry.sum[hbs_pkg::SLOT_C] = (use_c0 ? SMW'(colp0) : SMW'(0))
			+ SMW'(colp1) + SMW'(colp2);
		push_entry.sum[hbs_pkg::SLOT_D] = SMW'(colp1) + SMW'(colp2);

		if (use_c0 && use_top) begin
			push_entry.cnt[hbs_pkg::SLOT_A] = hbs_pkg::CNT9;
		end else if (use_c0 || use_top) begin
			push_entry.cnt[hbs_pkg::SLOT_A] = hbs_pkg::CNT6;
		end else begin
			push_entry.cnt[hbs_pkg::SLOT_A] = hbs_pkg::CNT4;
		end
		push_entry.cnt[hbs_pkg::SLOT_B] = use_top ? hbs_pkg::CNT6 : hbs_pkg::CNT4;
		push_entry.cnt[hbs_pkg::SLOT_C] = use_c0 ? hbs_pkg::CNT6 : hbs_pkg::CNT4;
		push_entry.cnt[hbs_pkg::SLOT_D] = hbs_pkg::CNT4;

		push_entry.col_prev = CDW'(col_m1);
		push_entry.col_cur  = CDW'(col_q);
		push_entry.row_prev = CDW'(row_m1);
		push_entry.row_cur  = CDW'(row_q);

		push = working && (push_entry.has != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hbs_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			hbs_pkg::F_IDLE: begin
				if (accept) begin
					state_d = hbs_pkg::F_WORK;
				end
			end
			hbs_pkg::F_WORK: begin
				state_d = hbs_pkg::F_IDLE;
			end
			default: begin
				state_d = hbs_pkg::F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			win_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (working) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= smp_q;
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + HW'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q <= in_sample;
		end
	end

endmodule

`default_nettype wire

// ===== src/hbs_queue.sv =====
`default_nettype none

module hbs_queue (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire hbs_pkg::entry_t push_data,
	output logic           space,
	input  wire logic      pop,
	output hbs_pkg::entry_t pop_data,
	output logic           avail
);

	localparam int PW = $clog2(hbs_pkg::Q_DEPTH);
	localparam int CW = $clog2(hbs_pkg::Q_DEPTH + 1);

	hbs_pkg::entry_t mem_q [hbs_pkg::Q_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign space    = (cnt_q != CW'(hbs_pkg::Q_DEPTH));
	assign avail    = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(hbs_pkg::Q_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(hbs_pkg::Q_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== src/hbs_back.sv =====
`default_nettype none

module hbs_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_avail,
	output logic                               pop,
	input  wire hbs_pkg::entry_t               head,
	input  wire logic [hbs_pkg::GAIN_W-1:0]    height_gain,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [hbs_pkg::COORD_W-1:0]        out_col,
	output logic [hbs_pkg::COORD_W-1:0]        out_row,
	output logic [hbs_pkg::HEIGHT_W-1:0]       out_height,
	output logic                               out_last,
	output logic                               out_frame_end
);

	localparam int PW = hbs_pkg::PROD_W;
	localparam int WW = hbs_pkg::PROD_W + hbs_pkg::RECIP_W;

	hbs_pkg::back_state_t state_q, state_d;
	hbs_pkg::entry_t      entry_q;
	logic [hbs_pkg::NUM_SLOTS-1:0] rem_q, pick_oh;
	hbs_pkg::slot_t       slot;

	logic [hbs_pkg::SUM_W-1:0]    sum_s1;
	hbs_pkg::count_t              cnt_s1, cnt_s2;
	logic [PW-1:0]                p_s2;
	logic [hbs_pkg::HEIGHT_W-1:0] height_q;
	logic [hbs_pkg::COORD_W-1:0]  col_s1, row_s1;
	logic                         last_s1, fe_s1;

	logic [PW-1:0]                num;
	logic [hbs_pkg::RECIP_W-1:0]  recip;
	logic [WW-1:0]                wide;
	logic [hbs_pkg::HEIGHT_W-1:0] quot;

	// lowest pending slot first
	always_comb begin
		if (rem_q[hbs_pkg::SLOT_A]) begin
			slot = hbs_pkg::SLOT_A;
		end else if (rem_q[hbs_pkg::SLOT_B]) begin
			slot = hbs_pkg::SLOT_B;
		end else if (rem_q[hbs_pkg::SLOT_C]) begin
			slot = hbs_pkg::SLOT_C;
		end else begin
			slot = hbs_pkg::SLOT_D;
		end
		pick_oh       = '0;
		pick_oh[slot] = 1'b1;
	end

	// divide by 4 with a shift, by 9 or 3 through a reciprocal; by 6 is a halving first
	always_comb begin
		num   = (cnt_s2 == hbs_pkg::CNT6) ? (p_s2 >> 1) : p_s2;
		recip = (cnt_s2 == hbs_pkg::CNT9) ? hbs_pkg::RECIP_9 : hbs_pkg::RECIP_3;
		wide  = WW'(num) * WW'(recip);
		if (cnt_s2 == hbs_pkg::CNT4) begin
			quot = hbs_pkg::HEIGHT_W'(p_s2 >> 2);
		end else begin
			quot = hbs_pkg::HEIGHT_W'(wide >> hbs_pkg::RECIP_SHIFT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hbs_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			hbs_pkg::B_IDLE: begin
				if (q_avail) begin
					pop     = 1'b1;
					state_d = hbs_pkg::B_PICK;
				end
			end
			hbs_pkg::B_PICK: begin
				state_d = hbs_pkg::B_MUL;
			end
			hbs_pkg::B_MUL: begin
				state_d = hbs_pkg::B_DIV;
			end
			hbs_pkg::B_DIV: begin
				state_d = hbs_pkg::B_OUT;
			end
			hbs_pkg::B_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = (rem_q != '0) ? hbs_pkg::B_PICK : hbs_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = hbs_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (pop) begin
			rem_q <= head.has;
		end else if (state_q == hbs_pkg::B_PICK) begin
			rem_q <= rem_q & ~pick_oh;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			entry_q <= head;
		end
		if (state_q == hbs_pkg::B_PICK) begin
			sum_s1  <= entry_q.sum[slot];
			cnt_s1  <= hbs_pkg::count_t'(entry_q.cnt[slot]);
			col_s1  <= (slot == hbs_pkg::SLOT_A || slot == hbs_pkg::SLOT_C) ?
				entry_q.col_prev : entry_q.col_cur;
			row_s1  <= (slot == hbs_pkg::SLOT_A || slot == hbs_pkg::SLOT_B) ?
				entry_q.row_prev : entry_q.row_cur;
			last_s1 <= ((rem_q & ~pick_oh) == '0);
			fe_s1   <= (slot == hbs_pkg::SLOT_D);
		end
		if (state_q == hbs_pkg::B_MUL) begin
			p_s2   <= PW'(sum_s1) * PW'(height_gain);
			cnt_s2 <= cnt_s1;
		end
		if (state_q == hbs_pkg::B_DIV) begin
			height_q <= quot;
		end
	end

	assign out_col       = col_s1;
	assign out_row       = row_s1;
	assign out_height    = height_q;
	assign out_last      = last_s1;
	assign out_frame_end = fe_s1;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int SAMPLE_W     = hbs_pkg::SAMPLE_W;
	localparam int COORD_W      = hbs_pkg::COORD_W;
	localparam int HEIGHT_W     = hbs_pkg::HEIGHT_W;
	localparam int OUT_TDATA_W  = hbs_pkg::OUT_TDATA_W;
	localparam int CFG_IDX_W    = hbs_pkg::CFG_IDX_W;
	localparam int CFG_DIM_W    = hbs_pkg::CFG_DIM_W;
	localparam int GAIN_W       = hbs_pkg::GAIN_W;

	localparam int GRID_MAX     = 1024;
	localparam int QUIET_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef struct packed {
		logic [COORD_W-1:0]  col;
		logic [COORD_W-1:0]  row;
		logic [HEIGHT_W-1:0] height;
		logic                last;
		logic                fe;
	} grid_point_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [SAMPLE_W-1:0]       s_axis_tdata = '0;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]    m_axis_tdata;
	logic                      m_axis_tlast;
	logic                      m_axis_tuser;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index = hbs_pkg::REG_GRID_WIDTH;
	logic [GAIN_W-1:0]         cfg_data = '0;

	// filter state mirrored for prediction
	logic [CFG_DIM_W-1:0]      grid_w = hbs_pkg::RESET_GRID_DIM;
	logic [CFG_DIM_W-1:0]      grid_h = hbs_pkg::RESET_GRID_DIM;
	logic [GAIN_W-1:0]         gain = hbs_pkg::RESET_GAIN;
	logic [SAMPLE_W-1:0]       prev1_line [GRID_MAX];
	logic [SAMPLE_W-1:0]       prev2_line [GRID_MAX];
	logic [5:0][SAMPLE_W-1:0]  win_cols = '0;
	int unsigned               cur_col = 0;
	int unsigned               cur_row = 0;

	logic [SAMPLE_W-1:0]       sample_q [$];
	grid_point_t               smoothed_q [$];
	grid_point_t               want_pt;
	int                        send_idle_pct = 0;
	int                        recv_idle_pct = 0;
	int                        samples_queued = 0;
	int                        samples_taken = 0;
	int                        points_checked = 0;
	int                        reg_writes = 0;
	int                        fail_count = 0;
	int                        cycle_count = 0;

	heightmap_box_smooth_3x3 uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int unsigned clamp_dim(input logic [CFG_DIM_W-1:0] v);
		if (v < 2) return 2;
		if (v > GRID_MAX) return GRID_MAX;
		return 32'(v);
	endfunction

	// nb[col][row]; sums columns c0..2 and rows r0..2, then scales by the gain and divides by the count
	function automatic logic [HEIGHT_W-1:0] box_mean(input logic [2:0][2:0][SAMPLE_W-1:0] nb,
			input int c0, input int r0);
		int unsigned sum;
		int unsigned cnt;
		int c;
		int r;
		sum = 0;
		cnt = 0;
		for (c = c0; c < 3; c++) begin
			for (r = r0; r < 3; r++) begin
				sum += nb[c][r];
				cnt++;
			end
		end
		return HEIGHT_W'((sum * gain) / cnt);
	endfunction

	function automatic void push_point(input int unsigned col, input int unsigned row,
			input logic [HEIGHT_W-1:0] hgt, input logic fe, input logic last);
		grid_point_t p;
		p.col = col[COORD_W-1:0];
		p.row = row[COORD_W-1:0];
		p.height = hgt;
		p.fe = fe;
		p.last = last;
		smoothed_q.push_back(p);
	endfunction

	function automatic void smooth_sample(input logic [SAMPLE_W-1:0] smp);
		int unsigned w;
		int unsigned h;
		int unsigned x;
		int unsigned y;
		int c0;
		int r0;
		int n;
		int k;
		logic [SAMPLE_W-1:0] top;
		logic [SAMPLE_W-1:0] mid;
		logic [2:0][2:0][SAMPLE_W-1:0] nb;
		logic emit_a;
		logic emit_b;
		logic emit_c;
		logic emit_d;
		w = clamp_dim(grid_w);
		h = clamp_dim(grid_h);
		x = cur_col;
		y = cur_row;
		top = (y >= 2) ? prev2_line[x] : '0;
		mid = (y >= 1) ? prev1_line[x] : '0;
		nb[0][0] = win_cols[0];
		nb[0][1] = win_cols[1];
		nb[0][2] = win_cols[2];
		nb[1][0] = win_cols[3];
		nb[1][1] = win_cols[4];
		nb[1][2] = win_cols[5];
		nb[2][0] = top;
		nb[2][1] = mid;
		nb[2][2] = smp;
		c0 = (x >= 2) ? 0 : 1;
		r0 = (y >= 2) ? 0 : 1;
		// points above-left, above, left, and this one once the last row is in
		emit_a = (y >= 1) && (x >= 1);
		emit_b = (y >= 1) && (x == w - 1);
		emit_c = (y >= 1) && (y == h - 1) && (x >= 1);
		emit_d = (y >= 1) && (y == h - 1) && (x == w - 1);
		n = emit_a + emit_b + emit_c + emit_d;
		k = 0;
		if (emit_a) begin
			k++;
			push_point(x - 1, y - 1, box_mean(nb, c0, r0), 1'b0, k == n);
		end
		if (emit_b) begin
			k++;
			push_point(x, y - 1, box_mean(nb, 1, r0), 1'b0, k == n);
		end
		if (emit_c) begin
			k++;
			push_point(x - 1, y, box_mean(nb, c0, 1), 1'b0, k == n);
		end
		if (emit_d) begin
			k++;
			push_point(x, y, box_mean(nb, 1, 1), 1'b1, k == n);
		end
		win_cols[0] = win_cols[3];
		win_cols[1] = win_cols[4];
		win_cols[2] = win_cols[5];
		win_cols[3] = top;
		win_cols[4] = mid;
		win_cols[5] = smp;
		prev2_line[x] = prev1_line[x];
		prev1_line[x] = smp;
		x++;
		if (x >= w) begin
			x = 0;
			y++;
			if (y >= h) y = 0;
		end
		cur_col = x;
		cur_row = y;
	endfunction

	function automatic void feed(input logic [SAMPLE_W-1:0] v);
		sample_q.push_back(v);
		samples_queued++;
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	// wait for every sample taken and every point seen, then let the pipeline drain
	task automatic quiesce();
		while (samples_taken != samples_queued || smoothed_q.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input hbs_pkg::cfg_reg_t idx, input logic [GAIN_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		reg_writes++;
		case (idx)
			hbs_pkg::REG_GRID_WIDTH: begin
				grid_w = val[CFG_DIM_W-1:0];
				cur_col = 0;
				cur_row = 0;
			end
			hbs_pkg::REG_GRID_HEIGHT: begin
				grid_h = val[CFG_DIM_W-1:0];
				cur_col = 0;
				cur_row = 0;
			end
			hbs_pkg::REG_HEIGHT_GAIN: gain = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic random_phase(input int budget);
		int sent;
		int n;
		int split;
		int style;
		int i;
		logic [GAIN_W-1:0] wv;
		logic [GAIN_W-1:0] hv;
		sent = 0;
		while (sent < budget) begin
			quiesce();
			case ($urandom_range(9))
				0: begin
					wv = GAIN_W'($urandom_range(1));
					hv = GAIN_W'($urandom_range(2, 5));
				end
				1: begin
					wv = GAIN_W'($urandom_range(7, 40));
					hv = GAIN_W'($urandom_range(3));
				end
				2: begin
					wv = GAIN_W'($urandom_range(2, 3));
					hv = GAIN_W'($urandom_range(7, 12));
				end
				default: begin
					wv = GAIN_W'($urandom_range(2, 6));
					hv = GAIN_W'($urandom_range(2, 6));
				end
			endcase
			if ($urandom_range(1)) begin
				write_reg(hbs_pkg::REG_GRID_WIDTH, wv);
				write_reg(hbs_pkg::REG_GRID_HEIGHT, hv);
			end else begin
				write_reg(hbs_pkg::REG_GRID_HEIGHT, hv);
				write_reg(hbs_pkg::REG_GRID_WIDTH, wv);
			end
			write_reg(hbs_pkg::REG_HEIGHT_GAIN, pick_gain());
			n = clamp_dim(wv[CFG_DIM_W-1:0]) * clamp_dim(hv[CFG_DIM_W-1:0]);
			split = -1;
			case ($urandom_range(5))
				0: n = $urandom_range(1, n - 1);      // frame left unfinished
				1: split = $urandom_range(1, n - 1);  // gain change inside the frame
				2: n = 2 * n;                         // two frames back to back
				default: ;
			endcase
			style = $urandom_range(3);
			for (i = 0; i < n; i++) begin
				if (i == split) begin
					quiesce();
					write_reg(hbs_pkg::REG_HEIGHT_GAIN, pick_gain());
				end
				if (style == 0) feed($urandom_range(1) ? 8'hFF : 8'h00);
				else feed(SAMPLE_W'($urandom));
			end
			sent += n;
		end
	endtask

	// driver: next beat from the queue once the current one is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || s_axis_tready) begin
				if (s_axis_tvalid) begin
					smooth_sample(s_axis_tdata);
					samples_taken++;
				end
				if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tdata <= sample_q.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result beat with the oldest predicted point
	always @(posedge clk) begin
		if (arst_n) begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				if (smoothed_q.size() == 0) begin
					$error("unexpected result beat: col %0d row %0d",
						m_axis_tdata[COORD_W-1:0], m_axis_tdata[2*COORD_W-1:COORD_W]);
					fail_count++;
				end else begin
					want_pt = smoothed_q.pop_front();
					points_checked++;
					if (m_axis_tdata[COORD_W-1:0] !== want_pt.col) begin
						$error("out_col: expected %0d, got %0d", want_pt.col,
							m_axis_tdata[COORD_W-1:0]);
						fail_count++;
					end
					if (m_axis_tdata[2*COORD_W-1:COORD_W] !== want_pt.row) begin
						$error("out_row: expected %0d, got %0d", want_pt.row,
							m_axis_tdata[2*COORD_W-1:COORD_W]);
						fail_count++;
					end
					if (m_axis_tdata[2*COORD_W+HEIGHT_W-1:2*COORD_W] !== want_pt.height) begin
						$error("smoothed_height: expected %0d, got %0d", want_pt.height,
							m_axis_tdata[2*COORD_W+HEIGHT_W-1:2*COORD_W]);
						fail_count++;
					end
					if (m_axis_tdata[OUT_TDATA_W-1:2*COORD_W+HEIGHT_W] !== '0) begin
						$error("tdata padding: expected 0, got %0h",
							m_axis_tdata[OUT_TDATA_W-1:2*COORD_W+HEIGHT_W]);
						fail_count++;
					end
					if (m_axis_tlast !== want_pt.last) begin
						$error("last_of_run: expected %0d, got %0d", want_pt.last, m_axis_tlast);
						fail_count++;
					end
					if (m_axis_tuser !== want_pt.fe) begin
						$error("frame_end: expected %0d, got %0d", want_pt.fe, m_axis_tuser);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$error("timeout with %0d points still expected", smoothed_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 15;
		recv_idle_pct = 83;

		// sizes below the minimum, every point a corner, largest result
		write_reg(hbs_pkg::REG_GRID_WIDTH, 16'd0);
		write_reg(hbs_pkg::REG_GRID_HEIGHT, 16'd1);
		write_reg(hbs_pkg::REG_HEIGHT_GAIN, 16'hFFFF);
		repeat (4) feed(8'hFF);
		quiesce();
		// zero gain on the wrapped frame
		write_reg(hbs_pkg::REG_HEIGHT_GAIN, 16'd0);
		repeat (4) feed(SAMPLE_W'($urandom));
		quiesce();
		// 3x3 frame has an inner point with the full neighbourhood
		write_reg(hbs_pkg::REG_GRID_WIDTH, 16'd3);
		write_reg(hbs_pkg::REG_GRID_HEIGHT, 16'd3);
		write_reg(hbs_pkg::REG_HEIGHT_GAIN, 16'd256);
		for (int i = 0; i < 9; i++) feed((i % 2) ? 8'hFF : 8'h00);
		// start of the next frame, cut off by the size writes that follow
		repeat (3) feed(SAMPLE_W'($urandom));

		random_phase(55);

		send_idle_pct = 83;
		recv_idle_pct = 15;
		random_phase(55);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(50);

		// upper width bits dropped, height above the maximum clamps, frame left open
		quiesce();
		write_reg(hbs_pkg::REG_GRID_WIDTH, 16'h0802);
		write_reg(hbs_pkg::REG_GRID_HEIGHT, 16'hFFFF);
		write_reg(hbs_pkg::REG_HEIGHT_GAIN, pick_gain());
		repeat (24) feed(SAMPLE_W'($urandom));

		quiesce();
		$display("%0d samples and %0d register writes, widths 2 to 40, heights 2 to 12 and 1024",
			samples_taken, reg_writes);
		$display("%0d smoothed points compared under sender, receiver and no-stall traffic",
			points_checked);
		if (fail_count == 0 && smoothed_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/hbs_pkg.sv
src/hbs_ram.sv
src/hbs_front.sv
src/hbs_queue.sv
src/hbs_back.sv
src/heightmap_box_smooth_3x3.sv
tb/testbench.sv
